### hdl/wss_pkg.sv
package wss_pkg;

  // table geometry
  localparam int ALPHABET_SIZE = 32;
  localparam int TBL_AW        = $clog2(ALPHABET_SIZE);

  // field widths
  localparam int IDX_W     = 5;
  localparam int VAL_W     = 32;
  localparam int SYM_W     = 7;
  localparam int CFG_IDX_W = 1;

  // generator
  localparam int GEN_W     = 48;
  localparam int RAND_W    = 31;
  localparam int RAND_LSB  = GEN_W - RAND_W;
  localparam int LCG_MUL_W = 35;
  localparam logic [LCG_MUL_W-1:0] LCG_MUL  = 35'h5DEECE66D;
  localparam logic [GEN_W-1:0]     LCG_ADD  = 48'hB;
  localparam logic [15:0]          SEED_LOW = 16'h330E;

  // letter code offset
  localparam logic [SYM_W-1:0] LETTER_BASE = 7'd64;

  // bit counter covers the longer of the multiply and divide loops
  localparam int CNT_W = $clog2(LCG_MUL_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'b1;

  // item functions
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DONE
  } wss_state_e;

endpackage

### hdl/wss_ram.sv
module wss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/weighted_symbol_sampler.sv
// Load beat: written into the table in the cycle it is accepted; next beat may follow at once.
// Draw beat: bit-serial multiply, add, restoring divide, then a scan that reads and compares
//   each table entry from entry 1 on until one matches; one draw in flight at a time.
// The draw uses the bit-serial multiplier, the restoring divider and the single table read port.
// Reset: async active low; FSM, output valid, total and generator (seed 0 -> 0x330E) cleared.
// Table contents are undefined after reset until loaded.
module weighted_symbol_sampler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wss_pkg::VAL_W-1:0]      cfg_data_i,
  // input beats
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [wss_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [wss_pkg::VAL_W-1:0]      entry_value_i,
  input  logic                           last_of_sequence_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wss_pkg::SYM_W-1:0]      symbol_o,
  output logic                           last_o,
  output logic                           error_o
);

  import wss_pkg::*;

  wss_state_e          state_q, state_d;
  logic [GEN_W-1:0]    rng_q, rng_d;       // generator state
  logic [GEN_W-1:0]    acc_q, acc_d;       // multiply accumulator
  logic [CNT_W-1:0]    cnt_q, cnt_d;       // bit counter for multiply/divide
  logic [RAND_W-1:0]   div_q, div_d;       // dividend, shifted out MSB first
  logic [VAL_W-1:0]    rem_q, rem_d;       // partial remainder
  logic [VAL_W-1:0]    total_q, total_d;
  logic [TBL_AW-1:0]   scan_q, scan_d;     // table entry under test
  logic [SYM_W-1:0]    res_sym_q, res_sym_d;
  logic                res_err_q, res_err_d;
  logic                res_last_q, res_last_d;
  logic                out_valid_q, out_valid_d;
  logic [SYM_W-1:0]    sym_q, sym_d;
  logic                last_q, last_d;
  logic                err_q, err_d;

  logic                in_accept;
  logic                tbl_we;
  logic                tbl_re;
  logic [VAL_W-1:0]    tbl_rdata;
  logic [GEN_W-1:0]    mul_sum;
  logic [GEN_W-1:0]    add_sum;
  logic [VAL_W:0]      rem_shift;
  logic [VAL_W:0]      rem_sub;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // loads beyond the table are dropped
  assign tbl_we = in_accept && (func_i == FUNC_LOAD) &&
                  ({{(32-IDX_W){1'b0}}, entry_index_i} < 32'(ALPHABET_SIZE));
  assign tbl_re = (state_q == ST_SCAN_RD);

  wss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (TBL_AW'(entry_index_i)),
    .wdata_i (entry_value_i),
    .re_i    (tbl_re),
    .raddr_i (scan_q),
    .rdata_o (tbl_rdata)
  );

  // one multiplier bit per cycle, MSB first: acc = 2*acc + bit*state
  assign mul_sum = {acc_q[GEN_W-2:0], 1'b0} + (LCG_MUL[cnt_q] ? rng_q : '0);
  assign add_sum = acc_q + LCG_ADD;

  // restoring divide step; only the remainder is kept
  assign rem_shift = {rem_q, div_q[RAND_W-1]};
  assign rem_sub   = rem_shift - {1'b0, total_q};

  always_comb begin
    state_d     = state_q;
    rng_d       = rng_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    div_d       = div_q;
    rem_d       = rem_q;
    total_d     = total_q;
    scan_d      = scan_q;
    res_sym_d   = res_sym_q;
    res_err_d   = res_err_q;
    res_last_d  = res_last_q;
    sym_d       = sym_q;
    last_d      = last_q;
    err_d       = err_q;
    // result beat leaves when not stalled
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_accept && (func_i == FUNC_DRAW)) begin
          acc_d      = '0;
          cnt_d      = CNT_W'(LCG_MUL_W - 1);
          res_last_d = last_of_sequence_i;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d = mul_sum;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        rng_d     = add_sum;
        div_d     = add_sum[GEN_W-1:RAND_LSB];
        rem_d     = '0;
        cnt_d     = CNT_W'(RAND_W - 1);
        res_sym_d = '0;
        res_err_d = 1'b1;
        // zero total: generator advanced, error result
        state_d   = (total_q == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        rem_d = rem_sub[VAL_W] ? rem_shift[VAL_W-1:0] : rem_sub[VAL_W-1:0];
        div_d = {div_q[RAND_W-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          scan_d  = TBL_AW'(1);
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (rem_q < tbl_rdata) begin
          res_sym_d = LETTER_BASE + SYM_W'(scan_q);
          res_err_d = 1'b0;
          state_d   = ST_DONE;
        end else if (scan_q == TBL_AW'(ALPHABET_SIZE - 1)) begin
          // no entry matched
          state_d = ST_DONE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          sym_d       = res_sym_q;
          last_d      = res_last_q;
          err_d       = res_err_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // the user must write registers only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEED:  rng_d   = {cfg_data_i, SEED_LOW};
        CFG_TOTAL: total_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rng_q       <= {{(GEN_W-16){1'b0}}, SEED_LOW};
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rng_q       <= rng_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    scan_q     <= scan_d;
    res_sym_q  <= res_sym_d;
    res_err_q  <= res_err_d;
    res_last_q <= res_last_d;
    sym_q      <= sym_d;
    last_q     <= last_d;
    err_q      <= err_d;
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = sym_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

### hdl/wss_checker.sv
module wss_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           func_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [wss_pkg::SYM_W-1:0]      symbol_o,
  input  logic                           last_o,
  input  logic                           error_o
);

  import wss_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o) &&
    $stable(last_o) && $stable(error_o))
    else $error("result beat changed under stall");

  a_err_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> symbol_o == '0)
    else $error("error beat with nonzero symbol");

  a_sym_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> (symbol_o > LETTER_BASE) &&
    ({{(32-SYM_W){1'b0}}, symbol_o} < 32'(ALPHABET_SIZE) + 32'(LETTER_BASE)))
    else $error("symbol outside the table");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_DRAW |=> in_stall_o)
    else $error("draw accepted without going busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && func_i == FUNC_LOAD |=> !in_stall_o)
    else $error("load beat stalled the next beat");

endmodule

bind weighted_symbol_sampler wss_checker u_wss_checker (.*);

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import wss_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RST_CYCLES    = 11;
  // longest quiet stretch of a good run is a send gap, a full draw and
  // a result stall run; this is many times that
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 150;
  localparam int PHASES        = 8;
  localparam int PRINT_CAP     = 40;

  // lrand48 step: x' = a*x + c mod 2^48, seed sets the upper 32 bits
  localparam logic [47:0] GEN_MULT    = 48'h5DEECE66D;
  localparam logic [47:0] GEN_INC     = 48'hB;
  localparam logic [15:0] GEN_SEED_LO = 16'h330E;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             error;
  } draw_res_t;

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i        = '0;
  logic [VAL_W-1:0]     cfg_data_i         = '0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_stall_o;
  logic                 func_i             = FUNC_LOAD;
  logic [IDX_W-1:0]     entry_index_i      = '0;
  logic [VAL_W-1:0]     entry_value_i      = '0;
  logic                 last_of_sequence_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i        = 1'b0;
  logic [SYM_W-1:0]     symbol_o;
  logic                 last_o;
  logic                 error_o;

  weighted_symbol_sampler dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .entry_index_i      (entry_index_i),
    .entry_value_i      (entry_value_i),
    .last_of_sequence_i (last_of_sequence_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .symbol_o           (symbol_o),
    .last_o             (last_o),
    .error_o            (error_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // sampler mirror: generator, modulus and cumulative counts
  logic [47:0]      lcg_state = {32'h0, GEN_SEED_LO};
  logic [VAL_W-1:0] modulus   = '0;
  logic [VAL_W-1:0] cum_table [ALPHABET_SIZE];

  beat_t     beat_q[$];       // beats waiting for the driver
  draw_res_t pending_draws[$]; // predicted symbols not yet seen

  int beats_queued = 0;
  int beats_in     = 0;
  int loads_in     = 0;
  int draws_in     = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int errors       = 0;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("ERROR: result %0d %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  // one accepted beat: loads update the table, draws step the generator and scan
  task automatic predict_beat(input beat_t b);
    logic [31:0] r;
    draw_res_t   res;
    bit          hit;
    if (b.func == FUNC_LOAD) begin
      if (int'(b.idx) < ALPHABET_SIZE) cum_table[b.idx] = b.val;
      loads_in++;
    end else begin
      lcg_state  = lcg_state * GEN_MULT + GEN_INC;
      r          = {1'b0, lcg_state[47:17]};
      hit        = 1'b0;
      res.symbol = '0;
      res.error  = 1'b1;
      res.last   = b.last;
      if (modulus != 0) begin
        r = r % modulus;
        // entry 0 is skipped: letters start at index 1
        for (int j = 1; j < ALPHABET_SIZE; j++) begin
          if (!hit && r < cum_table[j]) begin
            hit        = 1'b1;
            res.symbol = SYM_W'(j) + LETTER_BASE;
            res.error  = 1'b0;
          end
        end
      end
      pending_draws.push_back(res);
      draws_in++;
    end
  endtask

  task automatic send_beat(input logic f, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val, input logic lst);
    beat_t b;
    b.func = f;
    b.idx  = idx;
    b.val  = val;
    b.last = lst;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  // register write; only called once the sampler is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SEED) lcg_state = {data, GEN_SEED_LO};
    else if (idx == CFG_TOTAL) modulus = data;
    reg_writes++;
  endtask

  // all beats taken, all symbols back, then a settling wait for the last load
  task automatic settle();
    do @(posedge clk_i);
    while (beats_in != beats_queued || pending_draws.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver
  // bursts of random length, with an idle gap between them
  initial begin : beat_driver
    beat_t cur;
    bit    took;
    int    burst_left;
    int    gap_left;
    burst_left = 1;
    gap_left   = 0;
    cur        = '0;
    forever begin
      @(posedge clk_i);
      took = rst_ni && in_valid_i && !in_stall_o;
      if (took) begin
        predict_beat(cur);
        beats_in++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 1;
        end
      end
      if (took || !in_valid_i) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rst_ni && beat_q.size() != 0) begin
          cur                = beat_q.pop_front();
          func_i             <= cur.func;
          entry_index_i      <= cur.idx;
          entry_value_i      <= cur.val;
          last_of_sequence_i <= cur.last;
          in_valid_i         <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------- result stalls
  // modes: free-running, coin flip, rare stalls, long on/off runs
  initial begin : result_stall
    int   mode;
    int   len;
    int   run;
    logic level;
    run   = 0;
    level = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(40, 250);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= ($urandom_range(0, 7) == 0);
          default: begin
            if (run == 0) begin
              run   = $urandom_range(1, 25);
              level = ~level;
            end
            run--;
            out_stall_i <= level;
          end
        endcase
      end
    end
  end

  // ------------------------------------------------------- result monitor
  initial begin : result_monitor
    draw_res_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
        results_seen++;
        if (pending_draws.size() == 0) begin
          flag_mismatch("unexpected beat", {25'b0, symbol_o}, '0);
        end else begin
          want = pending_draws.pop_front();
          if (symbol_o !== want.symbol)
            flag_mismatch("symbol", 32'(symbol_o), 32'(want.symbol));
          if (last_o !== want.last)
            flag_mismatch("last", 32'(last_o), 32'(want.last));
          if (error_o !== want.error)
            flag_mismatch("error", 32'(error_o), 32'(want.error));
        end
      end
    end
  end

  // ------------------------------------------------------------- watchdog
  initial begin : watchdog
    int idle;
    int seen;
    idle = 0;
    seen = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (beats_in + results_seen != seen) begin
        seen = beats_in + results_seen;
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ----------------------------------------------------------------- tests

  // every entry gets written before any scan; entry 0 holds the maximum,
  // which must never come out as a letter
  task automatic test_table_fill();
    for (int j = 0; j < ALPHABET_SIZE; j++)
      send_beat(FUNC_LOAD, IDX_W'(j), (j == 0) ? 32'hFFFF_FFFF : 32'(j * 8), (j % 2) == 1);
  endtask

  // total is still zero from reset: error, and the generator must still step
  task automatic test_zero_total();
    send_beat(FUNC_DRAW, '0, '0, 1'b0);
    send_beat(FUNC_DRAW, '1, '1, 1'b1);
    settle();
  endtask

  // modulus far above the top count: draws find no entry
  task automatic test_no_match();
    write_reg(CFG_TOTAL, 32'hFFFF_FFFF);
    repeat (3) send_beat(FUNC_DRAW, IDX_W'($urandom), $urandom, 1'($urandom));
    settle();
  endtask

  // seed extremes, modulus of one, first entry at zero and at full scale
  task automatic test_extremes();
    write_reg(CFG_SEED, 32'h0);
    write_reg(CFG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_TOTAL, 32'd1);
    send_beat(FUNC_DRAW, '0, '0, 1'b0);
    send_beat(FUNC_LOAD, IDX_W'(1), 32'h0, 1'b1);
    send_beat(FUNC_DRAW, '0, '0, 1'b0);
    send_beat(FUNC_LOAD, IDX_W'(1), 32'hFFFF_FFFF, 1'b0);
    send_beat(FUNC_DRAW, '0, '0, 1'b1);
    settle();
    write_reg(CFG_TOTAL, 32'd249);
    repeat (4) send_beat(FUNC_DRAW, IDX_W'($urandom), $urandom, 1'($urandom));
    settle();
  endtask

  // each phase: new seed and modulus, a fresh cumulative table, then a run
  // of draws with the odd stray load mixed in
  task automatic test_random_phases();
    logic [31:0] acc;
    logic [31:0] scale;
    logic [31:0] total;
    logic [31:0] seed_val;
    int          n_draws;
    int          pick;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      pick = $urandom_range(0, 7);
      seed_val = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      write_reg(CFG_SEED, seed_val);

      case ($urandom_range(0, 3))
        0:       scale = 32'd3;
        1:       scale = 32'd100;
        2:       scale = 32'h000F_FFFF;
        default: scale = 32'h03FF_FFFF;
      endcase
      acc = '0;
      if ($urandom_range(0, 1)) send_beat(FUNC_LOAD, '0, $urandom, 1'($urandom));
      for (int j = 1; j < ALPHABET_SIZE; j++) begin
        acc += $urandom_range(0, scale);
        send_beat(FUNC_LOAD, IDX_W'(j), acc, 1'($urandom));
      end

      // mostly the true sum; sometimes too big, zero, or arbitrary
      pick = $urandom_range(0, 9);
      if (pick <= 6)      total = acc;
      else if (pick == 7) total = acc + $urandom_range(1, 1000);
      else if (pick == 8) total = '0;
      else                total = $urandom;
      // loads above do not touch the modulus, so wait for them first
      settle();
      write_reg(CFG_TOTAL, total);

      n_draws = $urandom_range(12, 24);
      for (int k = 0; k < n_draws; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_beat(FUNC_LOAD, IDX_W'($urandom), $urandom, 1'($urandom));
        else
          send_beat(FUNC_DRAW, IDX_W'($urandom), $urandom,
                    (k == n_draws - 1) || ($urandom_range(0, 5) == 0));
      end
    end
  endtask

  // ------------------------------------------------------------ main flow
  initial begin : main_flow
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_zero_total();
    test_no_match();
    test_extremes();
    test_random_phases();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input beats (%0d loads, %0d draws), %0d symbols checked",
             beats_in, loads_in, draws_in, results_seen);
    $display("%0d register writes across %0d random table phases, %0d mismatches",
             reg_writes, PHASES, errors);
    if (errors == 0 && pending_draws.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
